// File: rtl/cteb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the COO to ELLPACK builder.
// Used by the controller, the datapath, the top level and the checker.
package cteb_pkg;

   localparam int MAX_ROWS    = 1024;
   localparam int MAX_WIDTH   = 32;

   localparam int ROW_W       = 10;
   localparam int COL_IN_W    = 16;
   localparam int VALUE_W     = 64;
   localparam int ADDR_W      = 15;
   localparam int COL_OUT_W   = 17;
   localparam int STATUS_W    = 2;

   localparam int CFG_ROWS_W  = 11;
   localparam int CFG_WIDTH_W = 6;
   localparam int CFG_COLS_W  = 17;
   localparam int CSR_IDX_W   = 2;

   localparam int FILL_W      = $clog2(MAX_WIDTH + 1);
   localparam int CLR_W       = $clog2(MAX_ROWS);
   localparam int PROD_W      = ROW_W + FILL_W;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2,
      STATUS_WIDTH = 2'd3
   } status_type;

   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_PAD    = 1'b1
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_ROWS    = 2'd0,
      CSR_ROW_WIDTH   = 2'd1,
      CSR_NUM_COLUMNS = 2'd2,
      CSR_PAD_VALUE   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic clear_step;
      logic capture;
      logic emit_err;
      logic emit_ins;
      logic emit_pad;
      logic cnt_inc;
      logic cnt_zero;
      logic slot_load;
      logic slot_adv;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_pad;
      logic req_err;
      logic row_full;
      logic pad_empty;
      logic slot_last;
   } dp_status_type;

endpackage

// File: rtl/coo_to_ellpack_builder.sv
`timescale 1ns / 1ps
// COO to ELLPACK builder top level: controller plus datapath.
// Each transaction is captured, then evaluated; a pad then sweeps the row's empty slots.
// Insert/error results are registered from the evaluation state; pad results follow one per cycle.
// The fill-count memory port (one read, one write) and the pad sweep set this schedule.
// After reset the fill-count memory is cleared entry by entry with busy high; csr writes are taken.
// Results are registered and the receiver cannot stall them.
module coo_to_ellpack_builder
   import cteb_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_type,
   input  logic [ROW_W-1:0]            req_row,
   input  logic [COL_IN_W-1:0]         req_col_in,
   input  logic [VALUE_W-1:0]          req_value_in,
   output logic                        rsp_valid,
   output logic [ADDR_W-1:0]           rsp_write_addr,
   output logic signed [COL_OUT_W-1:0] rsp_col_out,
   output logic [VALUE_W-1:0]          rsp_value_out,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic                        rsp_last,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [VALUE_W-1:0]          csr_data
);

   cmd_type       cmd;
   dp_status_type dp_status;

   cteb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .dp_status (dp_status),
      .cmd       (cmd),
      .busy      (busy)
   );

   cteb_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .dp_status      (dp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_type       (req_type),
      .req_row        (req_row),
      .req_col_in     (req_col_in),
      .req_value_in   (req_value_in),
      .rsp_valid      (rsp_valid),
      .rsp_write_addr (rsp_write_addr),
      .rsp_col_out    (rsp_col_out),
      .rsp_value_out  (rsp_value_out),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

endmodule

// File: rtl/cteb_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: clearing pass, request capture, evaluation, pad sweep.
// Depends on cteb_pkg for the command and status structs.
module cteb_ctrl
   import cteb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type dp_status,
   output cmd_type       cmd,
   output logic          busy
);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_EVAL  = 4'b0100,
      ST_PAD   = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (dp_status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_IDLE;
            if (dp_status.req_err) begin
               cmd.emit_err = 1'b1;
            end else if (!dp_status.is_pad) begin
               if (dp_status.row_full) begin
                  cmd.emit_err = 1'b1;
               end else begin
                  cmd.emit_ins = 1'b1;
                  cmd.cnt_inc  = 1'b1;
               end
            end else if (dp_status.pad_empty) begin
               cmd.cnt_zero = 1'b1;
            end else begin
               cmd.slot_load = 1'b1;
               state_in      = ST_PAD;
            end
         end
         ST_PAD: begin
            cmd.emit_pad = 1'b1;
            cmd.slot_adv = 1'b1;
            if (dp_status.slot_last) begin
               cmd.cnt_zero = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// File: rtl/cteb_datapath.sv
`timescale 1ns / 1ps
// Datapath: configuration registers, row fill-count memory, address math, result registers.
// Depends on cteb_pkg; driven by commands from cteb_ctrl.
module cteb_datapath
   import cteb_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   output dp_status_type               dp_status,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [VALUE_W-1:0]          csr_data,
   input  logic                        req_type,
   input  logic [ROW_W-1:0]            req_row,
   input  logic [COL_IN_W-1:0]         req_col_in,
   input  logic [VALUE_W-1:0]          req_value_in,
   output logic                        rsp_valid,
   output logic [ADDR_W-1:0]           rsp_write_addr,
   output logic signed [COL_OUT_W-1:0] rsp_col_out,
   output logic [VALUE_W-1:0]          rsp_value_out,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic                        rsp_last
);

   logic [CFG_ROWS_W-1:0]  num_rows_ff;
   logic [CFG_WIDTH_W-1:0] row_width_ff;
   logic [CFG_COLS_W-1:0]  num_columns_ff;
   logic [VALUE_W-1:0]     pad_value_ff;

   req_kind_type           kind_ff;
   logic [ROW_W-1:0]       row_ff;
   logic [COL_IN_W-1:0]    col_ff;
   logic [VALUE_W-1:0]     value_ff;

   logic [FILL_W-1:0]      cnt_mem [MAX_ROWS];
   logic [FILL_W-1:0]      fill_ff;
   logic [CLR_W-1:0]       clr_ff;
   logic [FILL_W-1:0]      slot_ff;

   logic                   wr_en;
   logic [CLR_W-1:0]       wr_idx;
   logic [FILL_W-1:0]      wr_data;

   logic [FILL_W-1:0]      w_eff;
   logic                   width_err;
   logic                   range_err;
   logic [FILL_W-1:0]      slot_sel;
   logic [PROD_W-1:0]      addr_sum;
   status_type             err_code;

   logic                   rsp_valid_ff;
   logic [ADDR_W-1:0]      addr_ff;
   logic [COL_OUT_W-1:0]   col_out_ff;
   logic [VALUE_W-1:0]     value_out_ff;
   status_type             status_ff;
   logic                   last_ff;

   // configuration port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff    <= CFG_ROWS_W'(MAX_ROWS);
         row_width_ff   <= CFG_WIDTH_W'(MAX_WIDTH);
         num_columns_ff <= CFG_COLS_W'(65536);
         pad_value_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_NUM_ROWS:    num_rows_ff    <= csr_data[CFG_ROWS_W-1:0];
            CSR_ROW_WIDTH:   row_width_ff   <= csr_data[CFG_WIDTH_W-1:0];
            CSR_NUM_COLUMNS: num_columns_ff <= csr_data[CFG_COLS_W-1:0];
            CSR_PAD_VALUE:   pad_value_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_kind_type'(req_type);
         row_ff   <= req_row;
         col_ff   <= req_col_in;
         value_ff <= req_value_in;
      end
   end

   // fill-count memory: one write port, one registered read port
   always_comb begin
      wr_en   = 1'b0;
      wr_idx  = CLR_W'(row_ff);
      wr_data = '0;
      if (cmd.clear_step) begin
         wr_en  = 1'b1;
         wr_idx = clr_ff;
      end else if (cmd.cnt_inc) begin
         wr_en   = 1'b1;
         wr_data = fill_ff + FILL_W'(1);
      end else if (cmd.cnt_zero) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cnt_mem[wr_idx] <= wr_data;
      end
      if (cmd.capture) begin
         fill_ff <= cnt_mem[CLR_W'(req_row)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + CLR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.slot_load) begin
         slot_ff <= fill_ff;
      end else if (cmd.slot_adv) begin
         slot_ff <= slot_ff + FILL_W'(1);
      end
   end

   // checks and address
   assign w_eff = (32'(row_width_ff) > 32'(MAX_WIDTH)) ? FILL_W'(MAX_WIDTH)
                                                      : FILL_W'(row_width_ff);
   assign width_err = CFG_COLS_W'(row_width_ff) > num_columns_ff;
   assign range_err = (32'(row_ff) >= 32'(num_rows_ff)) || (32'(row_ff) >= 32'(MAX_ROWS));
   assign slot_sel  = cmd.emit_pad ? slot_ff : fill_ff;
   assign addr_sum  = PROD_W'(row_ff) * PROD_W'(w_eff) + PROD_W'(slot_sel);

   always_comb begin
      if (width_err) begin
         err_code = STATUS_WIDTH;
      end else if (range_err) begin
         err_code = STATUS_RANGE;
      end else begin
         err_code = STATUS_FULL;
      end
   end

   assign dp_status.clear_last = (clr_ff == CLR_W'(MAX_ROWS - 1));
   assign dp_status.is_pad     = (kind_ff == REQ_PAD);
   assign dp_status.req_err    = width_err || range_err;
   assign dp_status.row_full   = (fill_ff >= w_eff);
   assign dp_status.pad_empty  = (fill_ff >= w_eff);
   assign dp_status.slot_last  = ((FILL_W + 1)'(slot_ff) + (FILL_W + 1)'(1))
                                 == (FILL_W + 1)'(w_eff);

   // result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit_err || cmd.emit_ins || cmd.emit_pad;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_err) begin
         addr_ff      <= '0;
         col_out_ff   <= '0;
         value_out_ff <= '0;
         status_ff    <= err_code;
         last_ff      <= 1'b1;
      end else if (cmd.emit_ins) begin
         addr_ff      <= addr_sum[ADDR_W-1:0];
         col_out_ff   <= COL_OUT_W'(col_ff);
         value_out_ff <= value_ff;
         status_ff    <= STATUS_OK;
         last_ff      <= 1'b1;
      end else if (cmd.emit_pad) begin
         addr_ff      <= addr_sum[ADDR_W-1:0];
         col_out_ff   <= '1;
         value_out_ff <= pad_value_ff;
         status_ff    <= STATUS_OK;
         last_ff      <= dp_status.slot_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_write_addr = addr_ff;
   assign rsp_col_out    = $signed(col_out_ff);
   assign rsp_value_out  = value_out_ff;
   assign rsp_status     = status_ff;
   assign rsp_last       = last_ff;

endmodule

// File: rtl/cteb_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the COO to ELLPACK builder, attached by bind.
// Depends on cteb_pkg for widths and status codes.
module cteb_checker
   import cteb_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic [ADDR_W-1:0]           rsp_write_addr,
   input logic signed [COL_OUT_W-1:0] rsp_col_out,
   input logic [VALUE_W-1:0]          rsp_value_out,
   input logic [STATUS_W-1:0]         rsp_status,
   input logic                        rsp_last
);

   // check that busy is raised by reset for the clearing pass
   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> rsp_last)
      else $error("error result not marked last");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |->
      (rsp_write_addr == '0 && rsp_col_out == '0 && rsp_value_out == '0))
      else $error("error result carries write data");

   a_pad_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> rsp_valid)
      else $error("pad burst broke before last");

endmodule

bind coo_to_ellpack_builder cteb_checker u_cteb_checker (.*);

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for coo_to_ellpack_builder: a queue-fed driver, a result monitor and a
// behavioral predictor of the ELLPACK slot writes. Depends on cteb_pkg and the builder RTL.
module tb_top;
   import cteb_pkg::*;

   typedef struct {
      req_kind_type           kind;
      logic [ROW_W-1:0]       row;
      logic [COL_IN_W-1:0]    col;
      logic [VALUE_W-1:0]     value;
   } nz_req_type;

   typedef struct {
      logic [ADDR_W-1:0]           addr;
      logic signed [COL_OUT_W-1:0] col;
      logic [VALUE_W-1:0]          value;
      status_type                  status;
      logic                        last;
   } slot_write_type;

   logic                        clock;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic                        req_type = 1'b0;
   logic [ROW_W-1:0]            req_row = '0;
   logic [COL_IN_W-1:0]         req_col_in = '0;
   logic [VALUE_W-1:0]          req_value_in = '0;
   logic                        rsp_valid;
   logic [ADDR_W-1:0]           rsp_write_addr;
   logic signed [COL_OUT_W-1:0] rsp_col_out;
   logic [VALUE_W-1:0]          rsp_value_out;
   logic [STATUS_W-1:0]         rsp_status;
   logic                        rsp_last;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index = '0;
   logic [VALUE_W-1:0]          csr_data = '0;

   // predictor state
   logic [CFG_ROWS_W-1:0]  cfg_rows  = 11'd1024;
   logic [CFG_WIDTH_W-1:0] cfg_width = 6'd32;
   logic [CFG_COLS_W-1:0]  cfg_cols  = 17'd65536;
   logic [VALUE_W-1:0]     cfg_pad   = '0;
   logic [FILL_W-1:0]      row_fill [MAX_ROWS];

   nz_req_type     pending_reqs [$];
   slot_write_type slot_writes_due [$];
   nz_req_type     in_flight;
   slot_write_type due;
   logic        no_idle = 1'b0;
   int          mismatches = 0;
   int          accepted = 0;
   int          checked = 0;
   int          reg_writes = 0;

   coo_to_ellpack_builder dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_row        (req_row),
      .req_col_in     (req_col_in),
      .req_value_in   (req_value_in),
      .rsp_valid      (rsp_valid),
      .rsp_write_addr (rsp_write_addr),
      .rsp_col_out    (rsp_col_out),
      .rsp_value_out  (rsp_value_out),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic predict_slot_writes(input nz_req_type rq);
      int          w;
      int          nr;
      int          fill;
      int          base;
      int          s;
      slot_write_type sw;
      w = (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
      nr = (cfg_rows > MAX_ROWS) ? MAX_ROWS : cfg_rows;
      sw.addr = '0;
      sw.col = '0;
      sw.value = '0;
      sw.status = STATUS_OK;
      sw.last = 1'b1;
      if (cfg_width > cfg_cols) begin
         sw.status = STATUS_WIDTH;
         slot_writes_due.push_back(sw);
      end else if (int'(rq.row) >= nr) begin
         sw.status = STATUS_RANGE;
         slot_writes_due.push_back(sw);
      end else begin
         fill = row_fill[rq.row];
         base = int'(rq.row) * w;
         if (rq.kind == REQ_INSERT) begin
            if (fill >= w) begin
               sw.status = STATUS_FULL;
            end else begin
               sw.addr = ADDR_W'(base + fill);
               sw.col = {1'b0, rq.col};
               sw.value = rq.value;
               row_fill[rq.row] = FILL_W'(fill + 1);
            end
            slot_writes_due.push_back(sw);
         end else begin
            for (s = fill; s < w; s++) begin
               sw.addr = ADDR_W'(base + s);
               sw.col = '1;
               sw.value = cfg_pad;
               sw.last = (s + 1 == w);
               slot_writes_due.push_back(sw);
            end
            row_fill[rq.row] = '0;
         end
      end
   endtask

   // driver: hold a transaction until accepted, otherwise idle at random unless no_idle is set
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_slot_writes(in_flight);
            accepted++;
         end
         if (!start || !busy) begin
            if (pending_reqs.size() > 0 && (no_idle || $urandom_range(99) >= 35)) begin
               in_flight = pending_reqs.pop_front();
               start <= 1'b1;
               req_type <= in_flight.kind;
               req_row <= in_flight.row;
               req_col_in <= in_flight.col;
               req_value_in <= in_flight.value;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (slot_writes_due.size() == 0) begin
            $error("unexpected result: write_addr %0d status %0d", rsp_write_addr, rsp_status);
            mismatches++;
         end else begin
            due = slot_writes_due.pop_front();
            checked++;
            if (rsp_write_addr !== due.addr) begin
               $error("write_addr: expected %0d, got %0d", due.addr, rsp_write_addr);
               mismatches++;
            end
            if (rsp_col_out !== due.col) begin
               $error("col_out: expected %0d, got %0d", due.col, rsp_col_out);
               mismatches++;
            end
            if (rsp_value_out !== due.value) begin
               $error("value_out: expected %h, got %h", due.value, rsp_value_out);
               mismatches++;
            end
            if (rsp_status !== due.status) begin
               $error("status: expected %0d, got %0d", due.status, rsp_status);
               mismatches++;
            end
            if (rsp_last !== due.last) begin
               $error("last: expected %0d, got %0d", due.last, rsp_last);
               mismatches++;
            end
         end
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [VALUE_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      reg_writes++;
      case (idx)
         CSR_NUM_ROWS:    cfg_rows = data[CFG_ROWS_W-1:0];
         CSR_ROW_WIDTH:   cfg_width = data[CFG_WIDTH_W-1:0];
         CSR_NUM_COLUMNS: cfg_cols = data[CFG_COLS_W-1:0];
         CSR_PAD_VALUE:   cfg_pad = data;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [VALUE_W-1:0] rows, input logic [VALUE_W-1:0] width,
                            input logic [VALUE_W-1:0] cols, input logic [VALUE_W-1:0] pad);
      write_reg(CSR_NUM_ROWS, rows);
      write_reg(CSR_ROW_WIDTH, width);
      write_reg(CSR_NUM_COLUMNS, cols);
      write_reg(CSR_PAD_VALUE, pad);
   endtask

   task automatic push_req(input req_kind_type kind, input int row, input int col,
                           input logic [VALUE_W-1:0] value);
      nz_req_type rq;
      rq.kind = kind;
      rq.row = ROW_W'(row);
      rq.col = COL_IN_W'(col);
      rq.value = value;
      pending_reqs.push_back(rq);
   endtask

   task automatic queue_random_reqs(input int count);
      int      hot;
      nz_req_type rq;
      hot = (cfg_rows == 0) ? 1 : ((cfg_rows < 6) ? int'(cfg_rows) : 6);
      repeat (count) begin
         rq.kind = ($urandom_range(99) < 22) ? REQ_PAD : REQ_INSERT;
         rq.row = ($urandom_range(99) < 10) ? ROW_W'($urandom) : ROW_W'($urandom_range(hot - 1));
         rq.col = COL_IN_W'($urandom);
         rq.value = {$urandom, $urandom};
         pending_reqs.push_back(rq);
      end
   endtask

   // wait for the driver and the result stream to drain, then let a trailing pad finish
   task automatic settle();
      int guard;
      guard = 0;
      while ((pending_reqs.size() > 0 || start || slot_writes_due.size() > 0) && guard < 40000) begin
         @(posedge clock);
         guard++;
      end
      if (guard >= 40000) begin
         $error("results still outstanding: %0d", slot_writes_due.size());
         mismatches++;
         slot_writes_due.delete();
      end
      repeat (40) @(posedge clock);
   endtask

   task automatic random_phase(input logic [VALUE_W-1:0] rows, input logic [VALUE_W-1:0] width,
                               input logic [VALUE_W-1:0] cols, input logic [VALUE_W-1:0] pad,
                               input logic steady);
      configure(rows, width, cols, pad);
      no_idle = steady;
      queue_random_reqs(47);
      settle();
      no_idle = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < MAX_ROWS; i++) row_fill[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: field extremes and pads of partial, nearly empty and empty rows
      push_req(REQ_INSERT, 0, 0, 64'h0);
      push_req(REQ_INSERT, 1023, 16'hFFFF, '1);
      push_req(REQ_INSERT, 1023, 16'h1234, 64'h5555_AAAA_5555_AAAA);
      push_req(REQ_PAD, 1023, 16'hFFFF, '1);
      push_req(REQ_PAD, 0, 0, 64'h0);
      push_req(REQ_PAD, 2, 0, 64'h0);
      settle();

      // narrow rows: full row, pad of full row, column beyond range, row out of range
      configure(64'hFFFF_FFFF_FFFF_F804, 2, 3, 64'hA5A5_5A5A_0FF0_F00F);
      push_req(REQ_INSERT, 3, 7, 64'h1);
      push_req(REQ_INSERT, 3, 16'hFFFF, 64'h8000_0000_0000_0000);
      push_req(REQ_INSERT, 3, 1, 64'h2);
      push_req(REQ_PAD, 3, 0, 64'h0);
      push_req(REQ_INSERT, 3, 2, 64'h3);
      push_req(REQ_PAD, 3, 0, 64'h0);
      push_req(REQ_INSERT, 4, 0, 64'h4);
      push_req(REQ_PAD, 1023, 0, 64'h0);
      settle();

      // width exceeds columns, then zero columns
      configure(4, 5, 3, '1);
      push_req(REQ_INSERT, 0, 1, 64'h5);
      push_req(REQ_PAD, 0, 0, 64'h0);
      settle();
      configure(4, 1, 0, '1);
      push_req(REQ_INSERT, 1, 1, 64'h6);
      settle();

      // zero width, then zero rows
      configure(4, 0, 0, 64'h0);
      push_req(REQ_INSERT, 1, 1, 64'h7);
      push_req(REQ_PAD, 1, 0, 64'h0);
      settle();
      configure(0, 0, 0, 64'h0);
      push_req(REQ_INSERT, 0, 1, 64'h8);
      push_req(REQ_PAD, 0, 0, 64'h0);
      settle();

      // saturated rows and width at the register maxima
      configure(11'h7FF, 6'h3F, 17'h1FFFF, '1);
      push_req(REQ_INSERT, 1023, 16'hFFFF, '1);
      push_req(REQ_PAD, 1023, 0, 64'h0);
      settle();

      random_phase(1024, 32, 65536, {$urandom, $urandom}, 1'b1);
      random_phase(8, 8, 40, 64'h0, 1'b0);
      random_phase(8, 2, 40, '1, 1'b0);
      random_phase(1, 1, 1, {$urandom, $urandom}, 1'b0);
      random_phase($urandom_range(1, 16), $urandom_range(1, 10), $urandom_range(10, 65536),
                   {$urandom, $urandom}, 1'b0);
      random_phase(11'h7FF, 6'h3F, 17'h1FFFF, {$urandom, $urandom}, 1'b0);

      $display("Covered %0d insert and pad transactions, %0d checked results,", accepted, checked);
      $display("across %0d register writes including error and saturation settings.", reg_writes);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
